FILE: design/tms_pkg.sv
// Shared types and codes for the thermal mode supervisor.
// No dependencies; every design file refers to it by scoped names.
`default_nettype none

package tms_pkg;

	localparam int TEMP_BITS = 16;
	localparam int CNT_W     = 16;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	// input item kinds
	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_MODE   = 2'd1;
	localparam logic [1:0] FN_HEATER = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ALARM      = 2'd0;
	localparam logic [1:0] REG_HEATER_OFF = 2'd1;
	localparam logic [1:0] REG_HEATER_ON  = 2'd2;

	localparam logic signed [TEMP_BITS-1:0] ALARM_RST      = TEMP_BITS'(600);
	localparam logic signed [TEMP_BITS-1:0] HEATER_OFF_RST = TEMP_BITS'(300);
	localparam logic signed [TEMP_BITS-1:0] HEATER_ON_RST  = TEMP_BITS'(100);

	// operating modes
	localparam logic MODE_SAFE    = 1'b0;
	localparam logic MODE_NOMINAL = 1'b1;

	// event codes
	localparam logic [1:0] EV_ALARM    = 2'd0;
	localparam logic [1:0] EV_HEATER   = 2'd1;
	localparam logic [1:0] EV_MODE     = 2'd2;
	localparam logic [1:0] EV_OVERFLOW = 2'd3;

	// severities
	localparam logic [1:0] SEV_INFO = 2'd0;
	localparam logic [1:0] SEV_LOW  = 2'd1;
	localparam logic [1:0] SEV_HIGH = 2'd2;

	// completion status
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_NOT_PERMITTED = 2'd1;
	localparam logic [1:0] ST_BAD_PARAM     = 2'd2;

	// result kinds
	localparam logic KIND_EVENT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// bit positions of the event flags, in emission order
	localparam int EVB_ALARM    = 0;
	localparam int EVB_HEATER   = 1;
	localparam int EVB_MODE     = 2;
	localparam int EVB_OVERFLOW = 3;
	localparam int NEV          = 4;

	// everything the back end needs to play out the beats of one item
	typedef struct packed {
		logic [NEV-1:0]       ev;
		logic [TEMP_BITS-1:0] temp;
		logic [CNT_W-1:0]     ovf;
		logic                 mode;        // mode after the item
		logic                 heater;      // heater after the item
		logic                 old_heater;  // heater seen by the alarm event
		logic [1:0]           status;
	} plan_t;

endpackage

`default_nettype wire

FILE: design/tms_front.sv
// Front end: configuration registers, supervisor state and item classification.
// Depends on tms_pkg; produces one plan_t per accepted item.
`default_nettype none

module tms_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire  [1:0]                  cfg_index,
	input  wire  [tms_pkg::TEMP_BITS-1:0] cfg_data,
	input  wire                         take,
	input  wire  [1:0]                  func,
	input  wire  signed [tms_pkg::TEMP_BITS-1:0] temperature,
	input  wire  [tms_pkg::CNT_W-1:0]   overflow_count,
	input  wire  [1:0]                  requested_mode,
	input  wire                         heater_request,
	output tms_pkg::plan_t              plan
);

	logic signed [tms_pkg::TEMP_BITS-1:0] alarm_thr_q, off_thr_q, on_thr_q;
	logic                                 mode_q, heater_q, latch_q;
	logic [tms_pkg::CNT_W-1:0]            prev_ovf_q;

	logic                                 mode_n, heater_n, latch_n;
	logic [tms_pkg::CNT_W-1:0]            prev_ovf_n;
	logic                                 ge_alarm, ge_off, le_on;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_thr_q <= tms_pkg::ALARM_RST;
			off_thr_q   <= tms_pkg::HEATER_OFF_RST;
			on_thr_q    <= tms_pkg::HEATER_ON_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tms_pkg::REG_ALARM:      alarm_thr_q <= cfg_data;
				tms_pkg::REG_HEATER_OFF: off_thr_q   <= cfg_data;
				tms_pkg::REG_HEATER_ON:  on_thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ge_alarm = temperature >= alarm_thr_q;
	assign ge_off   = temperature >= off_thr_q;
	assign le_on    = temperature <= on_thr_q;

	always_comb begin
		mode_n          = mode_q;
		heater_n        = heater_q;
		latch_n         = latch_q;
		prev_ovf_n      = prev_ovf_q;
		plan            = '0;
		plan.temp       = temperature;
		plan.ovf        = overflow_count;
		plan.old_heater = heater_q;
		plan.status     = tms_pkg::ST_OK;
		unique case (func)
			tms_pkg::FN_TICK: begin
				if (mode_q == tms_pkg::MODE_NOMINAL) begin
					if (ge_alarm) begin
						plan.ev[tms_pkg::EVB_ALARM]  = !latch_q;
						plan.ev[tms_pkg::EVB_HEATER] = heater_q;
						plan.ev[tms_pkg::EVB_MODE]   = 1'b1;
						latch_n  = 1'b1;
						mode_n   = tms_pkg::MODE_SAFE;
						heater_n = 1'b0;
					end else if (ge_off) begin
						plan.ev[tms_pkg::EVB_HEATER] = heater_q;
						heater_n = 1'b0;
					end else if (le_on) begin
						plan.ev[tms_pkg::EVB_HEATER] = !heater_q;
						heater_n = 1'b1;
					end
				end else begin
					plan.ev[tms_pkg::EVB_HEATER] = heater_q;
					heater_n = 1'b0;
				end
				if (!ge_off) begin
					latch_n = 1'b0;
				end
				if (overflow_count != prev_ovf_q) begin
					plan.ev[tms_pkg::EVB_OVERFLOW] = 1'b1;
					prev_ovf_n = overflow_count;
				end
			end
			tms_pkg::FN_MODE: begin
				if (requested_mode[1]) begin
					plan.status = tms_pkg::ST_BAD_PARAM;
				end else if (requested_mode[0] != mode_q) begin
					mode_n = requested_mode[0];
					plan.ev[tms_pkg::EVB_MODE] = 1'b1;
					if (requested_mode[0] == tms_pkg::MODE_SAFE) begin
						plan.ev[tms_pkg::EVB_HEATER] = heater_q;
						heater_n = 1'b0;
					end
				end
			end
			tms_pkg::FN_HEATER: begin
				if (mode_q == tms_pkg::MODE_SAFE) begin
					plan.status = tms_pkg::ST_NOT_PERMITTED;
				end else begin
					plan.ev[tms_pkg::EVB_HEATER] = heater_request != heater_q;
					heater_n = heater_request;
				end
			end
			default: plan.status = tms_pkg::ST_BAD_PARAM;
		endcase
		plan.mode   = mode_n;
		plan.heater = heater_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= tms_pkg::MODE_SAFE;
			heater_q   <= 1'b0;
			latch_q    <= 1'b0;
			prev_ovf_q <= '0;
		end else if (take) begin
			mode_q     <= mode_n;
			heater_q   <= heater_n;
			latch_q    <= latch_n;
			prev_ovf_q <= prev_ovf_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/tms_queue.sv
// Short plan queue between the front and back ends.
// Depends on tms_pkg for plan_t and the queue depth.
`default_nettype none

module tms_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr,
	input  tms_pkg::plan_t  wr_plan,
	output logic            full,
	input  wire             rd,
	output logic            q_empty,
	output tms_pkg::plan_t  head
);

	tms_pkg::plan_t                mem_q [tms_pkg::QDEPTH];
	logic [tms_pkg::QPTR_W-1:0]    wp_q, rp_q;
	logic [tms_pkg::QPTR_W:0]      cnt_q;

	assign full    = cnt_q == (tms_pkg::QPTR_W+1)'(tms_pkg::QDEPTH);
	assign q_empty = cnt_q == '0;
	assign head    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/tms_back.sv
// Back end: plays out the event beats and the status beat of each plan.
// Depends on tms_pkg; drives the registered result ports.
`default_nettype none

module tms_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        q_empty,
	input  tms_pkg::plan_t             head,
	output logic                       q_rd,
	input  wire                        pop,
	output logic                       empty,
	output logic                       kind,
	output logic [1:0]                 event_code,
	output logic [1:0]                 severity,
	output logic [tms_pkg::CNT_W-1:0]  event_value,
	output logic [1:0]                 status,
	output logic                       current_mode,
	output logic                       heater_line,
	output logic                       last
);

	logic [tms_pkg::NEV-1:0]    done_q, pend, pick;
	logic                       vld_q, load;
	logic                       kind_n, mode_n, heater_n;
	logic [1:0]                 code_n, sev_n;
	logic [tms_pkg::CNT_W-1:0]  value_n;
	logic                       kind_q, mode_q, heater_q, last_q;
	logic [1:0]                 code_q, sev_q, status_q;
	logic [tms_pkg::CNT_W-1:0]  value_q;

	assign pend = head.ev & ~done_q;
	assign load = (!vld_q || pop) && !q_empty;
	assign q_rd = load && (pend == '0);

	always_comb begin
		pick     = '0;
		kind_n   = tms_pkg::KIND_EVENT;
		code_n   = tms_pkg::EV_ALARM;
		sev_n    = tms_pkg::SEV_INFO;
		value_n  = '0;
		mode_n   = head.mode;
		heater_n = head.heater;
		if (pend[tms_pkg::EVB_ALARM]) begin
			pick[tms_pkg::EVB_ALARM] = 1'b1;
			sev_n    = tms_pkg::SEV_HIGH;
			value_n  = head.temp;
			mode_n   = tms_pkg::MODE_NOMINAL;
			heater_n = head.old_heater;
		end else if (pend[tms_pkg::EVB_HEATER]) begin
			pick[tms_pkg::EVB_HEATER] = 1'b1;
			code_n  = tms_pkg::EV_HEATER;
			value_n = tms_pkg::CNT_W'(head.heater);
		end else if (pend[tms_pkg::EVB_MODE]) begin
			pick[tms_pkg::EVB_MODE] = 1'b1;
			code_n  = tms_pkg::EV_MODE;
			value_n = tms_pkg::CNT_W'(head.mode);
		end else if (pend[tms_pkg::EVB_OVERFLOW]) begin
			pick[tms_pkg::EVB_OVERFLOW] = 1'b1;
			code_n  = tms_pkg::EV_OVERFLOW;
			sev_n   = tms_pkg::SEV_LOW;
			value_n = head.ovf;
		end else begin
			kind_n = tms_pkg::KIND_STATUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			done_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
			end else if (pop) begin
				vld_q <= 1'b0;
			end
			// clear the progress mask once the status beat leaves the plan
			if (q_rd) begin
				done_q <= '0;
			end else if (load) begin
				done_q <= done_q | pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_n;
			code_q   <= code_n;
			sev_q    <= sev_n;
			value_q  <= value_n;
			status_q <= kind_n ? head.status : tms_pkg::ST_OK;
			mode_q   <= mode_n;
			heater_q <= heater_n;
			last_q   <= kind_n;
		end
	end

	assign empty        = !vld_q;
	assign kind         = kind_q;
	assign event_code   = code_q;
	assign severity     = sev_q;
	assign event_value  = value_q;
	assign status       = status_q;
	assign current_mode = mode_q;
	assign heater_line  = heater_q;
	assign last         = last_q;

endmodule

`default_nettype wire

FILE: design/thermal_mode_supervisor.sv
// Thermal mode supervisor: SAFE/NOMINAL mode, hysteresis heater law, alarm latch.
// Depends on tms_pkg, tms_front, tms_queue and tms_back.
//
// Usage:
//   Input channel: drive func and its fields with push; an item is taken at a
//   clock edge where push is high and full is low. Ticks carry temperature and
//   overflow_count, mode commands requested_mode, heater commands heater_request.
//   Result channel: while empty is low the oldest beat sits on the result ports;
//   pop takes it. Each item yields zero to four event beats followed by one
//   status beat with last high.
//   Config channel: cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   Write only while no item is in flight.
// Timing:
//   The front end classifies an item in the cycle it is taken and can take one
//   item every cycle while the four-entry plan queue has room. The back end
//   emits one beat per cycle while pop is high; the beat count of each item
//   sets the sustained rate. The first beat of an item passes through the plan
//   queue and then the result register when the back end is free.
// Reset:
//   arst_n clears the queue and result register; thresholds return to 600, 300
//   and 100, the mode to SAFE, heater off, alarm latch and overflow history clear.
// Stall:
//   With pop low the result beat holds; the queue fills and full rises.
`default_nettype none

module thermal_mode_supervisor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [1:0]  func,
	input  wire  signed [15:0] temperature,
	input  wire  [15:0] overflow_count,
	input  wire  [1:0]  requested_mode,
	input  wire         heater_request,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	output logic        empty,
	input  wire         pop,
	output logic        kind,
	output logic [1:0]  event_code,
	output logic [1:0]  severity,
	output logic [15:0] event_value,
	output logic [1:0]  status,
	output logic        current_mode,
	output logic        heater_line,
	output logic        last
);

	tms_pkg::plan_t plan, head;
	logic           take, q_empty, q_rd;

	assign take = push && !full;

	tms_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.take           (take),
		.func           (func),
		.temperature    (temperature),
		.overflow_count (overflow_count),
		.requested_mode (requested_mode),
		.heater_request (heater_request),
		.plan           (plan)
	);

	tms_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_plan (plan),
		.full    (full),
		.rd      (q_rd),
		.q_empty (q_empty),
		.head    (head)
	);

	tms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.event_code   (event_code),
		.severity     (severity),
		.event_value  (event_value),
		.status       (status),
		.current_mode (current_mode),
		.heater_line  (heater_line),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: design/tms_checker.sv
// Port-level checks for the thermal mode supervisor, bound to the top level.
// Depends on tms_pkg for result codes.
`default_nettype none

module tms_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         empty,
	input wire         pop,
	input wire         kind,
	input wire  [1:0]  event_code,
	input wire  [1:0]  severity,
	input wire  [15:0] event_value,
	input wire  [1:0]  status,
	input wire         current_mode,
	input wire         heater_line,
	input wire         last
);

	// only the status beat closes an item
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == kind))
		else $error("last and kind disagree");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == tms_pkg::KIND_STATUS) |->
		(event_code == tms_pkg::EV_ALARM && severity == tms_pkg::SEV_INFO &&
		 event_value == 16'd0))
		else $error("status beat carries event fields");

	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == tms_pkg::KIND_EVENT) |-> status == tms_pkg::ST_OK)
		else $error("event beat carries a status");

	// heater can never be left on in SAFE once an item completes
	a_safe_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == tms_pkg::KIND_STATUS &&
		 current_mode == tms_pkg::MODE_SAFE) |-> !heater_line)
		else $error("heater on in SAFE");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_value) && $stable(kind)))
		else $error("stalled beat changed");

endmodule

bind thermal_mode_supervisor tms_checker u_tms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.kind         (kind),
	.event_code   (event_code),
	.severity     (severity),
	.event_value  (event_value),
	.status       (status),
	.current_mode (current_mode),
	.heater_line  (heater_line),
	.last         (last)
);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for thermal_mode_supervisor: directed and random ticks and commands
// under several threshold settings and handshake idle patterns, checked beat by beat.
// Depends on tms_pkg and the design sources only.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FN_UNUSED   = 2'd3;
	localparam logic [1:0] REQ_SAFE    = 2'd0;
	localparam logic [1:0] REQ_NOMINAL = 2'd1;
	localparam int QUIET_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED  = 100;

	typedef struct {
		logic [1:0]         fn;
		logic signed [15:0] temp;
		logic [15:0]        ovf;
		logic [1:0]         req_mode;
		logic               heat_req;
	} item_t;

	typedef struct {
		logic        kind;
		logic [1:0]  code;
		logic [1:0]  sev;
		logic [15:0] value;
		logic [1:0]  stat;
		logic        mode;
		logic        heater;
		logic        last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] func = '0;
	logic signed [15:0] temperature = '0;
	logic [15:0] overflow_count = '0;
	logic [1:0] requested_mode = '0;
	logic heater_request = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic empty;
	logic pop = 1'b0;
	logic kind;
	logic [1:0] event_code;
	logic [1:0] severity;
	logic [15:0] event_value;
	logic [1:0] status;
	logic current_mode;
	logic heater_line;
	logic last;

	thermal_mode_supervisor dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.func(func), .temperature(temperature), .overflow_count(overflow_count),
		.requested_mode(requested_mode), .heater_request(heater_request),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.empty(empty), .pop(pop),
		.kind(kind), .event_code(event_code), .severity(severity),
		.event_value(event_value), .status(status), .current_mode(current_mode),
		.heater_line(heater_line), .last(last)
	);

	item_t pending_items[$];
	beat_t expected_beats[$];

	// supervisor state as the block should hold it
	logic sv_mode = tms_pkg::MODE_SAFE;
	logic sv_heater = 1'b0;
	logic sv_latch = 1'b0;
	logic [15:0] sv_prev_ovf = '0;
	logic signed [15:0] thr_alarm = tms_pkg::ALARM_RST;
	logic signed [15:0] thr_off = tms_pkg::HEATER_OFF_RST;
	logic signed [15:0] thr_on = tms_pkg::HEATER_ON_RST;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int items_taken = 0;
	int beats_checked = 0;
	int event_beats = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;
	logic [15:0] gen_ovf = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic void add_beat(input logic k, input logic [1:0] code,
			input logic [1:0] sev, input logic [15:0] value,
			input logic [1:0] stat, input logic lst);
		beat_t b;
		b.kind = k;
		b.code = code;
		b.sev = sev;
		b.value = value;
		b.stat = stat;
		b.mode = sv_mode;
		b.heater = sv_heater;
		b.last = lst;
		expected_beats.push_back(b);
	endfunction

	function automatic void switch_heater(input logic on);
		if (on != sv_heater) begin
			sv_heater = on;
			add_beat(tms_pkg::KIND_EVENT, tms_pkg::EV_HEATER, tms_pkg::SEV_INFO,
				{15'd0, on}, tms_pkg::ST_OK, 1'b0);
		end
	endfunction

	function automatic logic [1:0] enter_mode(input logic [1:0] m);
		if (m > REQ_NOMINAL)
			return tms_pkg::ST_BAD_PARAM;
		if (m[0] == sv_mode)
			return tms_pkg::ST_OK;
		sv_mode = m[0];
		// entering SAFE drops the heater before the mode change is reported
		if (sv_mode == tms_pkg::MODE_SAFE)
			switch_heater(1'b0);
		add_beat(tms_pkg::KIND_EVENT, tms_pkg::EV_MODE, tms_pkg::SEV_INFO,
			{15'd0, m[0]}, tms_pkg::ST_OK, 1'b0);
		return tms_pkg::ST_OK;
	endfunction

	function automatic void predict_beats(input item_t it);
		logic [1:0] st;
		st = tms_pkg::ST_OK;
		case (it.fn)
			tms_pkg::FN_TICK: begin
				if (sv_mode == tms_pkg::MODE_NOMINAL) begin
					if (it.temp >= thr_alarm) begin
						if (!sv_latch) begin
							sv_latch = 1'b1;
							add_beat(tms_pkg::KIND_EVENT, tms_pkg::EV_ALARM,
								tms_pkg::SEV_HIGH, it.temp, tms_pkg::ST_OK, 1'b0);
						end
						void'(enter_mode(REQ_SAFE));
					end else if (it.temp >= thr_off) begin
						switch_heater(1'b0);
					end else if (it.temp <= thr_on) begin
						switch_heater(1'b1);
					end
				end else begin
					switch_heater(1'b0);
				end
				if (it.temp < thr_off)
					sv_latch = 1'b0;
				if (it.ovf != sv_prev_ovf) begin
					sv_prev_ovf = it.ovf;
					add_beat(tms_pkg::KIND_EVENT, tms_pkg::EV_OVERFLOW, tms_pkg::SEV_LOW,
						it.ovf, tms_pkg::ST_OK, 1'b0);
				end
			end
			tms_pkg::FN_MODE: st = enter_mode(it.req_mode);
			tms_pkg::FN_HEATER: begin
				if (sv_mode == tms_pkg::MODE_SAFE)
					st = tms_pkg::ST_NOT_PERMITTED;
				else
					switch_heater(it.heat_req);
			end
			default: st = tms_pkg::ST_BAD_PARAM;
		endcase
		add_beat(tms_pkg::KIND_STATUS, '0, '0, '0, st, 1'b1);
	endfunction

	// input driver: present the head of the pending list, idle at random
	always @(negedge clk) begin
		if (arst_n && pending_items.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			func <= pending_items[0].fn;
			temperature <= pending_items[0].temp;
			overflow_count <= pending_items[0].ovf;
			requested_mode <= pending_items[0].req_mode;
			heater_request <= pending_items[0].heat_req;
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: check popped beats, predict for taken items
	always @(posedge clk) begin : monitor_blk
		beat_t want;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (!empty && pop) begin
				moved = 1'b1;
				beats_checked++;
				if (expected_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					if (want.kind == tms_pkg::KIND_EVENT)
						event_beats++;
					check_field("kind", kind, want.kind);
					check_field("event_code", event_code, want.code);
					check_field("severity", severity, want.sev);
					check_field("event_value", event_value, want.value);
					check_field("status", status, want.stat);
					check_field("current_mode", current_mode, want.mode);
					check_field("heater_line", heater_line, want.heater);
					check_field("last", last, want.last);
				end
			end
			if (push && !full) begin
				moved = 1'b1;
				items_taken++;
				predict_beats(pending_items.pop_front());
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
		end
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	task automatic add_item(input logic [1:0] fn, input logic signed [15:0] temp,
			input logic [15:0] ovf, input logic [1:0] rm, input logic hr);
		item_t it;
		it.fn = fn;
		it.temp = temp;
		it.ovf = ovf;
		it.req_mode = rm;
		it.heat_req = hr;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_beats.size() != 0)
			@(posedge clk);
		// let the back end settle before touching the registers
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [1:0] idx, input logic signed [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tms_pkg::REG_ALARM: thr_alarm = value;
			tms_pkg::REG_HEATER_OFF: thr_off = value;
			default: thr_on = value;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic signed [15:0] a, input logic signed [15:0] off,
			input logic signed [15:0] on, input int send_pct, input int recv_pct,
			input int n_items);
		item_t it;
		int roll;
		logic signed [15:0] base;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		write_threshold(tms_pkg::REG_ALARM, a);
		write_threshold(tms_pkg::REG_HEATER_OFF, off);
		write_threshold(tms_pkg::REG_HEATER_ON, on);
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(99);
			it.fn = roll < 50 ? tms_pkg::FN_TICK : roll < 75 ? tms_pkg::FN_MODE :
				roll < 95 ? tms_pkg::FN_HEATER : FN_UNUSED;
			// mostly probe the thresholds, where the behavior turns
			roll = $urandom_range(99);
			if (roll < 60) begin
				case ($urandom_range(2))
					0: base = thr_alarm;
					1: base = thr_off;
					default: base = thr_on;
				endcase
				it.temp = base + 16'($urandom_range(4)) - 16'sd2;
			end else if (roll < 75) begin
				case ($urandom_range(2))
					0: it.temp = 16'sh8000;
					1: it.temp = 16'sh7fff;
					default: it.temp = '0;
				endcase
			end else begin
				it.temp = 16'($urandom());
			end
			roll = $urandom_range(99);
			it.ovf = roll < 60 ? gen_ovf : roll < 80 ? gen_ovf + 16'd1 : 16'($urandom());
			gen_ovf = it.ovf;
			roll = $urandom_range(99);
			it.req_mode = roll < 60 ? REQ_NOMINAL : roll < 80 ? REQ_SAFE :
				{1'b1, 1'($urandom_range(1))};
			it.heat_req = 1'($urandom_range(1));
			pending_items.push_back(it);
		end
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pass at reset thresholds (alarm 600, off 300, on 100), start in SAFE
		add_item(tms_pkg::FN_TICK, 16'sd0, 16'h0005, 2'd3, 1'b1);
		add_item(FN_UNUSED, 16'sh7fff, 16'hffff, REQ_NOMINAL, 1'b1);
		add_item(tms_pkg::FN_HEATER, 16'sd0, 16'h0000, REQ_NOMINAL, 1'b1);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, 2'd2, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, 2'd3, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_NOMINAL, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_NOMINAL, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sh8000, 16'h0005, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_HEATER, 16'sd0, 16'h0000, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_HEATER, 16'sd0, 16'h0000, REQ_SAFE, 1'b1);
		add_item(tms_pkg::FN_TICK, 16'sd200, 16'h0005, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sd300, 16'h0005, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sd100, 16'h0000, REQ_SAFE, 1'b0);
		// alarm, heater off, mode change and overflow from one tick
		add_item(tms_pkg::FN_TICK, 16'sd600, 16'hffff, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sh7fff, 16'hffff, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_NOMINAL, 1'b0);
		// latch still set: no second alarm, SAFE again
		add_item(tms_pkg::FN_TICK, 16'sd700, 16'haaaa, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sd299, 16'h5555, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_NOMINAL, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sd99, 16'h5555, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_TICK, 16'sh7fff, 16'h0000, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_HEATER, 16'sd0, 16'h0000, REQ_SAFE, 1'b0);
		add_item(tms_pkg::FN_MODE, 16'sd0, 16'h0000, REQ_SAFE, 1'b1);
		wait_drained();

		run_phase(16'sd600, 16'sd300, 16'sd100, 0, 0, 35);
		run_phase(16'sh7fff, 16'sh7fff, 16'sh8000, 75, 0, 35);
		run_phase(16'sh8000, 16'sh8000, 16'sh7fff, 0, 75, 35);
		run_phase(16'sd200, 16'sd150, 16'sd150, 16, 16, 35);
		run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 0, 0, 35);
		run_phase(16'sd1000, 16'sd400, -16'sd100, 16, 16, 35);

		if (expected_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
		$display("run covered %0d items, %0d result beats (%0d events), %0d register writes",
			items_taken, beats_checked, event_beats, reg_writes);
		$display("threshold sets: reset, extremes, inverted, overlapping, random; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
